// ----- sv/uas_pkg.sv -----
`default_nettype none

package uas_pkg;

    // Output queue depth, a power of two, at least two
    localparam int UAS_FIFO_DEPTH = 4;
    localparam int UAS_PTR_W      = $clog2(UAS_FIFO_DEPTH);
    localparam int UAS_CNT_W      = $clog2(UAS_FIFO_DEPTH + 1);

    // Pending byte count
    localparam logic [1:0] UAS_HELD_NONE = 2'd0;
    localparam logic [1:0] UAS_HELD_ONE  = 2'd1;
    localparam logic [1:0] UAS_HELD_TWO  = 2'd2;

    // Number of results written per beat
    localparam logic [1:0] UAS_WR_NONE = 2'd0;
    localparam logic [1:0] UAS_WR_ONE  = 2'd1;
    localparam logic [1:0] UAS_WR_TWO  = 2'd2;

    // Lead classes
    localparam logic [7:0] UAS_MASK_2B = 8'hE0;
    localparam logic [7:0] UAS_LEAD_2B = 8'hC0;
    localparam logic [7:0] UAS_MASK_3B = 8'hF0;
    localparam logic [7:0] UAS_LEAD_3B = 8'hE0;
    localparam logic [7:0] UAS_MASK_4B = 8'hF8;
    localparam logic [7:0] UAS_LEAD_4B = 8'hF0;

    // Known leads and continuation bytes
    localparam logic [7:0] UAS_C2      = 8'hC2;
    localparam logic [7:0] UAS_CB      = 8'hCB;
    localparam logic [7:0] UAS_E2      = 8'hE2;
    localparam logic [7:0] UAS_EF      = 8'hEF;
    localparam logic [7:0] UAS_NBSP    = 8'hA0;
    localparam logic [7:0] UAS_MOD_PL  = 8'h96;
    localparam logic [7:0] UAS_MOD_MI  = 8'h97;
    localparam logic [7:0] UAS_PUNCT   = 8'h80;
    localparam logic [7:0] UAS_PUNCT2  = 8'h81;
    localparam logic [7:0] UAS_MATH    = 8'h88;
    localparam logic [7:0] UAS_BOM2    = 8'hBB;
    localparam logic [7:0] UAS_BOM3    = 8'hBF;
    localparam logic [7:0] UAS_SP_LAST = 8'h8B;
    localparam logic [7:0] UAS_LSQ     = 8'h98;
    localparam logic [7:0] UAS_RSQ     = 8'h99;
    localparam logic [7:0] UAS_LDQ     = 8'h9C;
    localparam logic [7:0] UAS_RDQ     = 8'h9D;
    localparam logic [7:0] UAS_NNBSP   = 8'hAF;
    localparam logic [7:0] UAS_INVSEP  = 8'hA3;
    localparam logic [7:0] UAS_INVPL   = 8'hA4;
    localparam logic [7:0] UAS_MINUS   = 8'h92;

    // ASCII replacements
    localparam logic [7:0] UAS_A_SPACE = 8'h20;
    localparam logic [7:0] UAS_A_APOS  = 8'h27;
    localparam logic [7:0] UAS_A_QUOTE = 8'h22;
    localparam logic [7:0] UAS_A_PLUS  = 8'h2B;
    localparam logic [7:0] UAS_A_MINUS = 8'h2D;
    localparam logic [7:0] UAS_NO_SUB  = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       text_end;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_wr;

    function automatic logic is_lead_2b(input logic [7:0] x);
        return (x & UAS_MASK_2B) == UAS_LEAD_2B;
    endfunction

    function automatic logic is_lead_3b(input logic [7:0] x);
        return (x & UAS_MASK_3B) == UAS_LEAD_3B;
    endfunction

    function automatic logic is_lead_4b(input logic [7:0] x);
        return (x & UAS_MASK_4B) == UAS_LEAD_4B;
    endfunction

    // Leads that can open a known sequence
    function automatic logic is_known_lead(input logic [7:0] x);
        return x == UAS_C2 || x == UAS_CB || x == UAS_E2 || x == UAS_EF;
    endfunction

    function automatic logic [7:0] match_two(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] sub;
        sub = UAS_NO_SUB;
        if (lead == UAS_C2 && b == UAS_NBSP) begin
            sub = UAS_A_SPACE;
        end else if (lead == UAS_CB && b == UAS_MOD_PL) begin
            sub = UAS_A_PLUS;
        end else if (lead == UAS_CB && b == UAS_MOD_MI) begin
            sub = UAS_A_MINUS;
        end
        return sub;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (lead == UAS_E2) begin
            ok = b == UAS_PUNCT || b == UAS_PUNCT2 || b == UAS_MATH;
        end else if (lead == UAS_EF) begin
            ok = b == UAS_BOM2;
        end
        return ok;
    endfunction

    function automatic logic [7:0] match_three(input logic [7:0] lead, input logic [7:0] s,
                                               input logic [7:0] t);
        logic [7:0] sub;
        sub = UAS_NO_SUB;
        if (lead == UAS_EF) begin
            if (s == UAS_BOM2 && t == UAS_BOM3) sub = UAS_A_SPACE;
        end else if (lead == UAS_E2) begin
            if (s == UAS_PUNCT) begin
                if (t >= UAS_PUNCT && t <= UAS_SP_LAST) sub = UAS_A_SPACE;
                else if (t == UAS_LSQ || t == UAS_RSQ) sub = UAS_A_APOS;
                else if (t == UAS_LDQ || t == UAS_RDQ) sub = UAS_A_QUOTE;
                else if (t == UAS_NNBSP)               sub = UAS_A_SPACE;
            end else if (s == UAS_PUNCT2) begin
                if (t == UAS_NBSP || t == UAS_INVSEP) sub = UAS_A_SPACE;
                else if (t == UAS_INVPL)              sub = UAS_A_PLUS;
            end else if (s == UAS_MATH && t == UAS_MINUS) begin
                sub = UAS_A_MINUS;
            end
        end
        return sub;
    endfunction

endpackage

`default_nettype wire

// ----- sv/uas_in_if.sv -----
`default_nettype none

interface uas_in_if;
    logic               valid;
    logic               ready;
    uas_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/uas_out_if.sv -----
`default_nettype none

interface uas_out_if;
    logic               valid;
    logic               ready;
    uas_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/uas_core.sv -----
`default_nettype none

module uas_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire uas_pkg::t_in_item i_item,
    output logic                   o_ready,
    input  wire logic              i_room,
    output uas_pkg::t_wr           o_wr
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    logic [7:0] r_lead,   n_lead;
    logic [7:0] r_second, n_second;
    logic [1:0] r_count,  n_count;

    logic       w_adv;
    logic       w_fresh;
    logic       w_present;
    logic [1:0] w_nb;
    logic [7:0] w_b0, w_b1, w_sub2, w_sub3;

    assign w_adv   = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte  <= i_item.in_byte;
            r_in_final <= i_item.final_byte;
        end
    end

    assign w_sub2 = uas_pkg::match_two(r_lead, r_in_byte);
    assign w_sub3 = uas_pkg::match_three(r_lead, r_second, r_in_byte);

    always_comb begin
        n_lead    = r_lead;
        n_second  = r_second;
        n_count   = uas_pkg::UAS_HELD_NONE;
        w_b0      = r_in_byte;
        w_b1      = r_in_byte;
        w_nb      = uas_pkg::UAS_WR_NONE;
        w_fresh   = 1'b0;
        w_present = 1'b1;

        case (r_count)
            uas_pkg::UAS_HELD_ONE: begin
                if (uas_pkg::is_lead_2b(r_lead)) begin
                    if (w_sub2 != uas_pkg::UAS_NO_SUB) begin
                        w_b0 = w_sub2;
                        w_nb = uas_pkg::UAS_WR_ONE;
                    end else begin
                        w_fresh = 1'b1;
                    end
                end else if (uas_pkg::second_ok(r_lead, r_in_byte)) begin
                    n_second = r_in_byte;
                    n_count  = uas_pkg::UAS_HELD_TWO;
                end else begin
                    w_fresh = 1'b1;
                end
            end
            uas_pkg::UAS_HELD_TWO: begin
                if (w_sub3 != uas_pkg::UAS_NO_SUB) begin
                    w_b0 = w_sub3;
                    w_nb = uas_pkg::UAS_WR_ONE;
                end else begin
                    // failed sequence: pass the held continuation raw
                    w_b0    = r_second;
                    w_nb    = uas_pkg::UAS_WR_ONE;
                    w_fresh = 1'b1;
                end
            end
            default: begin
                w_fresh = 1'b1;
            end
        endcase

        if (w_fresh) begin
            if (uas_pkg::is_lead_2b(r_in_byte) || uas_pkg::is_lead_3b(r_in_byte)) begin
                if (uas_pkg::is_known_lead(r_in_byte)) begin
                    n_lead  = r_in_byte;
                    n_count = uas_pkg::UAS_HELD_ONE;
                end
            end else if (!uas_pkg::is_lead_4b(r_in_byte)) begin
                // append at the next free slot; w_b0/w_b1 already carry the byte
                if (w_nb == uas_pkg::UAS_WR_NONE) begin
                    w_nb = uas_pkg::UAS_WR_ONE;
                end else begin
                    w_nb = uas_pkg::UAS_WR_TWO;
                end
            end
        end

        if (r_in_final) begin
            // flush a held second byte raw; it is the current beat
            if (n_count == uas_pkg::UAS_HELD_TWO) begin
                w_b0 = n_second;
                w_nb = uas_pkg::UAS_WR_ONE;
            end
            n_lead   = '0;
            n_second = '0;
            n_count  = uas_pkg::UAS_HELD_NONE;
            if (w_nb == uas_pkg::UAS_WR_NONE) begin
                w_b0      = '0;
                w_nb      = uas_pkg::UAS_WR_ONE;
                w_present = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= '0;
            r_second <= '0;
            r_count  <= uas_pkg::UAS_HELD_NONE;
        end else if (w_adv) begin
            r_lead   <= n_lead;
            r_second <= n_second;
            r_count  <= n_count;
        end
    end

    always_comb begin
        o_wr.count              = w_adv ? w_nb : uas_pkg::UAS_WR_NONE;
        o_wr.item0.out_byte     = w_b0;
        o_wr.item0.byte_present = w_present;
        o_wr.item0.run_last     = w_nb == uas_pkg::UAS_WR_ONE;
        o_wr.item0.text_end     = r_in_final && (w_nb == uas_pkg::UAS_WR_ONE);
        o_wr.item1.out_byte     = w_b1;
        o_wr.item1.byte_present = w_present;
        o_wr.item1.run_last     = 1'b1;
        o_wr.item1.text_end     = r_in_final;
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_final) |=> (r_count == uas_pkg::UAS_HELD_NONE))
        else $error("state not cleared after end of text");

    a_final_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_final) |-> (o_wr.count != uas_pkg::UAS_WR_NONE))
        else $error("end of text gave no result");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && (o_wr.count != 2'd3))
        else $error("illegal pending or write count");

endmodule

`default_nettype wire

// ----- sv/uas_out_fifo.sv -----
`default_nettype none

module uas_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire uas_pkg::t_wr       i_wr,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output uas_pkg::t_out_item      o_item
);

    localparam int PtrW = uas_pkg::UAS_PTR_W;
    localparam int CntW = uas_pkg::UAS_CNT_W;

    uas_pkg::t_out_item r_mem [uas_pkg::UAS_FIFO_DEPTH];

    logic [PtrW-1:0] r_wptr, r_rptr, w_wptr1;
    logic [CntW-1:0] r_count, n_count;
    logic            w_rd;

    assign w_wptr1 = r_wptr + PtrW'(1);
    assign w_rd    = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];
    // room for a two-beat write
    assign o_room  = r_count <= CntW'(uas_pkg::UAS_FIFO_DEPTH - 2);
    assign n_count = r_count + CntW'(i_wr.count) - CntW'(w_rd);

    always_ff @(posedge i_clk) begin
        if (i_wr.count != uas_pkg::UAS_WR_NONE) begin
            r_mem[r_wptr] <= i_wr.item0;
        end
        if (i_wr.count == uas_pkg::UAS_WR_TWO) begin
            r_mem[w_wptr1] <= i_wr.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PtrW'(i_wr.count);
            r_rptr  <= r_rptr + PtrW'(w_rd);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.count != uas_pkg::UAS_WR_NONE) |-> o_room)
        else $error("write without room");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(uas_pkg::UAS_FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- sv/utf8_to_ascii_substituter.sv -----
// Channel   Dir  Payload                                          Handshake
// i_in      in   in_byte[7:0], final_byte                         valid/ready
// o_out     out  out_byte[7:0], byte_present, text_end, run_last  valid/ready
//
// One input beat per cycle while the queue has room; each beat gives zero,
// one or two result beats. An accepted beat is registered in the input
// stage, and its results are written to a four-entry queue; input stalls
// while fewer than two entries are free, so a slow sink throttles the input.
// Synchronous active-low reset clears the pending bytes and empties the queue.
`default_nettype none

module utf8_to_ascii_substituter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    uas_in_if.sink    i_in,
    uas_out_if.source o_out
);

    uas_pkg::t_wr w_wr;
    logic         w_room;

    uas_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ready (i_in.ready),
        .i_room  (w_room),
        .o_wr    (w_wr)
    );

    uas_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule

`default_nettype wire

// ----- verif/uas_text_checker.sv -----
`timescale 1ns / 1ps

module uas_text_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_ready,
    input  uas_pkg::t_in_item   i_in_data,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_ready,
    input  uas_pkg::t_out_item  i_out_data,
    output int                  o_fail_count,
    output int                  o_awaiting
);
    import uas_pkg::*;

    // Predictor state: pending lead, pending second byte, pending count
    logic [7:0] pend_lead;
    logic [7:0] pend_mid;
    logic [1:0] pend_cnt;

    logic [7:0] emit_buf [2];
    int         emit_n;

    t_out_item  expected_q [$];
    int         fail_total;
    int         result_idx;

    assign o_fail_count = fail_total;

    initial begin
        fail_total = 0;
        result_idx = 0;
        o_awaiting = 0;
        pend_lead  = '0;
        pend_mid   = '0;
        pend_cnt   = UAS_HELD_NONE;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t result %0d: %s", $time, result_idx, what);
        fail_total++;
    endtask

    task automatic emit(input logic [7:0] b);
        if (emit_n < 2) begin
            emit_buf[emit_n] = b;
            emit_n++;
        end
    endtask

    // Hold a known lead, drop any other lead, pass everything else
    task automatic take_fresh(input logic [7:0] x);
        if (x[7:5] == 3'b110) begin
            if (x == UAS_C2 || x == UAS_CB) begin
                pend_lead = x;
                pend_cnt  = UAS_HELD_ONE;
            end
        end else if (x[7:4] == 4'b1110) begin
            if (x == UAS_E2 || x == UAS_EF) begin
                pend_lead = x;
                pend_cnt  = UAS_HELD_ONE;
            end
        end else if (x[7:3] != 5'b11110) begin
            emit(x);
        end
    endtask

    function automatic logic [7:0] pair_sub(input logic [7:0] l, input logic [7:0] b);
        if (l == UAS_C2 && b == UAS_NBSP) return UAS_A_SPACE;
        if (l == UAS_CB && b == UAS_MOD_PL) return UAS_A_PLUS;
        if (l == UAS_CB && b == UAS_MOD_MI) return UAS_A_MINUS;
        return UAS_NO_SUB;
    endfunction

    function automatic logic mid_ok(input logic [7:0] l, input logic [7:0] b);
        return (l == UAS_E2 && (b == UAS_PUNCT || b == UAS_PUNCT2 || b == UAS_MATH))
            || (l == UAS_EF && b == UAS_BOM2);
    endfunction

    function automatic logic [7:0] triple_sub(input logic [7:0] l, input logic [7:0] s,
                                              input logic [7:0] t);
        logic [7:0] r;
        r = UAS_NO_SUB;
        if (l == UAS_EF) begin
            if (s == UAS_BOM2 && t == UAS_BOM3) r = UAS_A_SPACE;
        end else if (l == UAS_E2) begin
            case (s)
                UAS_PUNCT: begin
                    if ((t >= UAS_PUNCT && t <= UAS_SP_LAST) || t == UAS_NNBSP)
                        r = UAS_A_SPACE;
                    else if (t == UAS_LSQ || t == UAS_RSQ)
                        r = UAS_A_APOS;
                    else if (t == UAS_LDQ || t == UAS_RDQ)
                        r = UAS_A_QUOTE;
                end
                UAS_PUNCT2: begin
                    if (t == UAS_NBSP || t == UAS_INVSEP) r = UAS_A_SPACE;
                    else if (t == UAS_INVPL)              r = UAS_A_PLUS;
                end
                UAS_MATH: begin
                    if (t == UAS_MINUS) r = UAS_A_MINUS;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic predict_beat(input t_in_item it);
        logic [7:0] l;
        logic [7:0] m;
        logic [7:0] s;
        logic [1:0] c;
        logic       blank;
        t_out_item  r;
        int         k;
        l        = pend_lead;
        m        = pend_mid;
        c        = pend_cnt;
        emit_n   = 0;
        pend_cnt = UAS_HELD_NONE;
        case (c)
            UAS_HELD_ONE: begin
                if (l[7:5] == 3'b110) begin
                    s = pair_sub(l, it.in_byte);
                    if (s != UAS_NO_SUB) emit(s);
                    else                 take_fresh(it.in_byte);
                end else if (mid_ok(l, it.in_byte)) begin
                    pend_mid = it.in_byte;
                    pend_cnt = UAS_HELD_TWO;
                end else begin
                    take_fresh(it.in_byte);
                end
            end
            UAS_HELD_TWO: begin
                s = triple_sub(l, m, it.in_byte);
                if (s != UAS_NO_SUB) begin
                    emit(s);
                end else begin
                    // drop the lead, pass the held continuation raw
                    emit(m);
                    take_fresh(it.in_byte);
                end
            end
            default: take_fresh(it.in_byte);
        endcase
        if (it.final_byte) begin
            if (pend_cnt == UAS_HELD_TWO) emit(pend_mid);
            pend_lead = '0;
            pend_mid  = '0;
            pend_cnt  = UAS_HELD_NONE;
        end
        blank = it.final_byte && emit_n == 0;
        if (blank) begin
            emit_buf[0] = '0;
            emit_n      = 1;
        end
        for (k = 0; k < emit_n; k++) begin
            r.out_byte     = emit_buf[k];
            r.byte_present = !blank;
            r.run_last     = (k == emit_n - 1);
            r.text_end     = r.run_last && it.final_byte;
            expected_q.push_back(r);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat, byte %02h", got.out_byte));
        end else begin
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
            if (got.byte_present !== want.byte_present)
                report_mismatch($sformatf("byte_present %b, want %b",
                                          got.byte_present, want.byte_present));
            if (got.text_end !== want.text_end)
                report_mismatch($sformatf("text_end %b, want %b",
                                          got.text_end, want.text_end));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b",
                                          got.run_last, want.run_last));
        end
        result_idx++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pend_lead = '0;
            pend_mid  = '0;
            pend_cnt  = UAS_HELD_NONE;
            expected_q.delete();
            o_awaiting <= 0;
        end else begin
            // compare first: a result never belongs to a beat taken on the same edge
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
            o_awaiting <= expected_q.size();
        end
    end

endmodule

// ----- verif/utf8_to_ascii_substituter_tb.sv -----
`timescale 1ns / 1ps

module utf8_to_ascii_substituter_tb;
    import uas_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int ITEM_TARGET = 850;
    localparam int CALM_TAIL   = 120;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;

    logic clk = 1'b0;
    logic rst_n;

    uas_in_if  in_ch ();
    uas_out_if out_ch ();

    int         fail_count;
    int         awaiting;
    int         items_sent;
    int         cycle_cnt;
    bit         idle_on;
    logic [7:0] text_q [$];

    utf8_to_ascii_substituter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    uas_text_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_fail_count (fail_count),
        .o_awaiting   (awaiting)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("utf8_to_ascii_substituter test failed");
            $finish;
        end
    end

    // Result sink: ready drops in short random bursts while idling is on
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(0, 3);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input t_in_item it);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            in_ch.data  <= t_in_item'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_text();
        t_in_item it;
        int       i;
        for (i = 0; i < text_q.size(); i++) begin
            it.in_byte    = text_q[i];
            it.final_byte = (i == text_q.size() - 1);
            send_beat(it);
            items_sent++;
        end
    endtask

    task automatic push_three(input logic [7:0] l, input logic [7:0] s, input logic [7:0] t);
        text_q.push_back(l);
        text_q.push_back(s);
        text_q.push_back(t);
    endtask

    task automatic push_known(input int k);
        case (k)
            0:  begin text_q.push_back(UAS_C2); text_q.push_back(UAS_NBSP);   end
            1:  begin text_q.push_back(UAS_CB); text_q.push_back(UAS_MOD_PL); end
            2:  begin text_q.push_back(UAS_CB); text_q.push_back(UAS_MOD_MI); end
            15: push_three(UAS_E2, UAS_PUNCT,  UAS_NNBSP);
            16: push_three(UAS_E2, UAS_PUNCT2, UAS_NBSP);
            17: push_three(UAS_E2, UAS_PUNCT2, UAS_INVSEP);
            18: push_three(UAS_E2, UAS_PUNCT2, UAS_INVPL);
            19: push_three(UAS_E2, UAS_PUNCT,  UAS_LSQ);
            20: push_three(UAS_E2, UAS_PUNCT,  UAS_RSQ);
            21: push_three(UAS_E2, UAS_PUNCT,  UAS_LDQ);
            22: push_three(UAS_E2, UAS_PUNCT,  UAS_RDQ);
            23: push_three(UAS_E2, UAS_MATH,   UAS_MINUS);
            24: push_three(UAS_EF, UAS_BOM2,   UAS_BOM3);
            // the run of spaces E2 80 80 .. E2 80 8B
            default: push_three(UAS_E2, UAS_PUNCT, UAS_PUNCT + 8'(k - 3));
        endcase
    endtask

    // Broken sequence: a known lead followed by too little or a near miss
    task automatic push_broken();
        logic [7:0] l;
        int         shape;
        case ($urandom_range(0, 3))
            0:       l = UAS_C2;
            1:       l = UAS_CB;
            2:       l = UAS_E2;
            default: l = UAS_EF;
        endcase
        text_q.push_back(l);
        shape = $urandom_range(0, 3);
        if (shape == 1) begin
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (shape >= 2) begin
            if (l == UAS_E2) begin
                case ($urandom_range(0, 2))
                    0:       text_q.push_back(UAS_PUNCT);
                    1:       text_q.push_back(UAS_PUNCT2);
                    default: text_q.push_back(UAS_MATH);
                endcase
            end else if (l == UAS_EF) begin
                text_q.push_back(UAS_BOM2);
            end else begin
                text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            if (shape == 3) text_q.push_back(8'($urandom_range(0, 255)));
            else            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
    endtask

    task automatic fill_text();
        int pieces;
        int sel;
        int p;
        text_q.delete();
        pieces = $urandom_range(1, 8);
        for (p = 0; p < pieces; p++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)      push_known($urandom_range(0, 24));
            else if (sel < 75) text_q.push_back(8'($urandom_range(0, 255)));
            else if (sel < 85) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            else               push_broken();
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        items_sent  = 0;
        cycle_cnt   = 0;
        idle_on     = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Extremes, several substitution kinds, dropped leads, near misses,
        // end of text with a held second byte, empty end marker
        text_q = '{8'h00, 8'hFF, 8'hC2, 8'hA0, 8'hCB, 8'h97, 8'hE2, 8'h80, 8'h9C,
                   8'hEF, 8'hBB, 8'hBF, 8'hC3, 8'hC2, 8'h41, 8'hE2, 8'h80, 8'h41,
                   8'hE2, 8'h80};
        send_text();
        text_q = '{8'hF0};
        send_text();
        text_q = '{8'hE2, 8'h80, 8'hE2, 8'h81, 8'hA4, 8'hC2};
        send_text();

        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            fill_text();
            send_text();
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("utf8_to_ascii_substituter test passed");
        else
            $display("utf8_to_ascii_substituter test failed");
        $finish;
    end

endmodule
